/* hw/rtl/id3fw_pkg.sv */
// Shared types, constants and helpers for the ID3v2 frame walker.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package id3fw_pkg;

   // payload widths
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LEN_W      = 32;
   localparam int unsigned ID_W       = 32;
   localparam int unsigned ID_LEN_W   = 3;
   localparam int unsigned OFFSET_W   = 29;
   localparam int unsigned SIZE_W     = 28;

   // tag header magic
   localparam logic [7:0] MAGIC_I = 8'h49;
   localparam logic [7:0] MAGIC_D = 8'h44;
   localparam logic [7:0] MAGIC_3 = 8'h33;

   // byte positions inside the 10-byte tag header
   localparam logic [31:0] POS_MAGIC0  = 32'd0;
   localparam logic [31:0] POS_MAGIC1  = 32'd1;
   localparam logic [31:0] POS_MAGIC2  = 32'd2;
   localparam logic [31:0] POS_VERSION = 32'd3;
   localparam logic [31:0] POS_FLAGS   = 32'd5;
   localparam logic [31:0] POS_SIZE0   = 32'd6;
   localparam logic [31:0] POS_LAST    = 32'd9;

   localparam logic [31:0] HDR_LEN     = 32'd10;
   localparam logic [31:0] EXT_MIN     = 32'd4;
   localparam logic [31:0] EXT_MIN_END = HDR_LEN + EXT_MIN;
   localparam int unsigned EXT_FLAG_BIT = 6;
   localparam logic [3:0]  EXT_SIZE_BYTES = 4'd4;

   localparam logic [7:0] VER_2 = 8'd2;
   localparam logic [7:0] VER_4 = 8'd4;

   // frame header lengths and id lengths
   localparam logic [3:0] FRAME_HDR_V2   = 4'd6;
   localparam logic [3:0] FRAME_HDR_V34  = 4'd10;
   localparam logic [3:0] FRAME_SHIFT_MAX = 4'd8;
   localparam logic [2:0] ID_LEN_3 = 3'd3;
   localparam logic [2:0] ID_LEN_4 = 3'd4;

   localparam logic [6:0] SYNC_MASK = 7'h7f;

   typedef enum logic [4:0] {
      PH_DONE   = 5'b00001,
      PH_HEADER = 5'b00010,
      PH_EXT    = 5'b00100,
      PH_FRAME  = 5'b01000,
      PH_SKIP   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [ID_W-1:0]     frame_id;
      logic [ID_LEN_W-1:0] id_length;
      logic [OFFSET_W-1:0] data_offset;
      logic [SIZE_W-1:0]   data_size;
   } result_type;

   // 4 x 7-bit synchsafe integer, top bit of each byte dropped
   function automatic logic [27:0] synchsafe(input logic [31:0] s);
      return {s[30:24] & SYNC_MASK, s[22:16] & SYNC_MASK,
              s[14:8] & SYNC_MASK, s[6:0] & SYNC_MASK};
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/id3fw_req_if.sv */
// Input channel of the frame walker: one tag byte per word.
// Depends on id3fw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface id3fw_req_if;
   logic                             valid;
   logic                             ready;
   logic [id3fw_pkg::BYTE_W-1:0]     data_byte;
   logic                             first_byte;
   logic [id3fw_pkg::LEN_W-1:0]      buffer_length;

   modport source (output valid, output data_byte, output first_byte,
                   output buffer_length, input ready);
   modport sink   (input valid, input data_byte, input first_byte,
                   input buffer_length, output ready);
endinterface

`default_nettype wire

/* hw/rtl/id3fw_rsp_if.sv */
// Result channel of the frame walker: one frame descriptor per word.
// Depends on id3fw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface id3fw_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [id3fw_pkg::ID_W-1:0]         frame_id;
   logic [id3fw_pkg::ID_LEN_W-1:0]     id_length;
   logic [id3fw_pkg::OFFSET_W-1:0]     data_offset;
   logic [id3fw_pkg::SIZE_W-1:0]       data_size;

   modport source (output valid, output frame_id, output id_length,
                   output data_offset, output data_size, input ready);
   modport sink   (input valid, input frame_id, input id_length,
                   input data_offset, input data_size, output ready);
endinterface

`default_nettype wire

/* hw/rtl/id3v2_frame_walker.sv */
// ID3v2 frame walker, top level.
// Depends on id3fw_pkg, id3fw_req_if and id3fw_rsp_if.
//
// Usage:
//   req_bus carries the tag buffer one byte per word. first_byte marks byte 0
//   of a new buffer; buffer_length is sampled with it and parsing restarts.
//   rsp_bus carries one word per frame that fits inside the tag: id, id
//   length, data offset from the buffer start and data size.
//   Each accepted byte is handled by the parser state registers, so one byte
//   per cycle is taken for as long as the result side keeps up. A frame
//   descriptor is registered into the output register when the last byte of
//   its frame header is accepted, or into the skid register if the output word is stalled.
//   Results go through a two-word output buffer (output register plus skid
//   register): a stalled receiver does not stop input until both words are
//   held, and then req_bus.ready drops until rsp_bus.ready returns.
//   After reset the parser is idle and ignores bytes until a word with
//   first_byte set arrives; the output buffer is empty.
//   Padding, a bad header or a frame overrunning the tag end stop parsing
//   silently until the next first_byte.
`timescale 1ns / 1ps
`default_nettype none

module id3v2_frame_walker (
   input  wire logic   clock,
   input  wire logic   reset,
   id3fw_req_if.sink   req_bus,
   id3fw_rsp_if.source rsp_bus
);

   // parser state
   id3fw_pkg::phase_type phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] tag_end_ff, tag_end_in;
   logic [7:0]  version_ff, version_in;
   logic        ext_ff, ext_in;
   logic [63:0] shift_ff, shift_in;
   logic [3:0]  count_ff, count_in;
   logic [31:0] skip_ff, skip_in;

   // output buffer
   id3fw_pkg::result_type main_ff, main_in, skid_ff, skid_in;
   logic main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;

   // state as seen by this byte (after a restart on first_byte)
   id3fw_pkg::phase_type cur_phase;
   logic [31:0] cur_pos, cur_end, cur_skip;
   logic [7:0]  cur_ver, b;
   logic        cur_ext;
   logic [63:0] cur_shift;
   logic [3:0]  cur_count;

   logic        accept, push, pop;
   logic        is_v2, is_v4;
   logic [32:0] pos_inc;
   logic [31:0] hdr_raw;
   logic [32:0] hdr_lim;
   logic [31:0] end_bf;
   logic        bf_ok;
   logic [31:0] ext_raw, ext_size, ext_skip;
   logic [3:0]  ext_count;
   logic [63:0] fr_shift;
   logic [3:0]  fr_count, fr_hdr;
   logic [31:0] fr_id, fr_size;
   logic [33:0] fr_end;
   id3fw_pkg::result_type result;

   assign accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !skid_valid_ff;
   assign b = req_bus.data_byte;

   always_comb begin
      if (req_bus.first_byte) begin
         cur_phase = (req_bus.buffer_length < id3fw_pkg::HDR_LEN) ?
                     id3fw_pkg::PH_DONE : id3fw_pkg::PH_HEADER;
         cur_pos   = '0;
         cur_end   = req_bus.buffer_length;
         cur_ver   = '0;
         cur_ext   = 1'b0;
         cur_shift = '0;
         cur_count = '0;
         cur_skip  = '0;
      end else begin
         cur_phase = phase_ff;
         cur_pos   = pos_ff;
         cur_end   = tag_end_ff;
         cur_ver   = version_ff;
         cur_ext   = ext_ff;
         cur_shift = shift_ff;
         cur_count = count_ff;
         cur_skip  = skip_ff;
      end
   end

   assign is_v2   = (cur_ver == id3fw_pkg::VER_2);
   assign is_v4   = (cur_ver >= id3fw_pkg::VER_4);
   assign pos_inc = {1'b0, cur_pos} + 33'd1;

   // tag header size, valid on the last header byte
   assign hdr_raw = {cur_shift[23:0], b};
   assign hdr_lim = {1'b0, id3fw_pkg::HDR_LEN} + {5'b0, id3fw_pkg::synchsafe(hdr_raw)};

   // tag end that a frame start is checked against
   always_comb begin
      end_bf = cur_end;
      if (cur_phase == id3fw_pkg::PH_HEADER && cur_pos == id3fw_pkg::POS_LAST &&
          hdr_lim < {1'b0, cur_end}) begin
         end_bf = hdr_lim[31:0];
      end
   end

   // a frame header starting at the next byte must fit before the tag end
   assign bf_ok = ({1'b0, pos_inc} + {30'b0, id3fw_pkg::FRAME_HDR_V2} <= {2'b0, end_bf}) &&
                  (is_v2 ||
                   ({1'b0, pos_inc} + {30'b0, id3fw_pkg::FRAME_HDR_V34} <= {2'b0, end_bf}));

   // extended header size
   assign ext_raw   = {cur_shift[23:0], b};
   assign ext_size  = is_v4 ? {4'b0, id3fw_pkg::synchsafe(ext_raw)} : ext_raw;
   assign ext_skip  = (ext_size < id3fw_pkg::EXT_MIN) ? '0 : ext_size - id3fw_pkg::EXT_MIN;
   assign ext_count = cur_count + 4'd1;

   // frame header
   assign fr_shift = (cur_count < id3fw_pkg::FRAME_SHIFT_MAX) ?
                     {cur_shift[55:0], b} : cur_shift;
   assign fr_count = cur_count + 4'd1;
   assign fr_hdr   = is_v2 ? id3fw_pkg::FRAME_HDR_V2 : id3fw_pkg::FRAME_HDR_V34;

   always_comb begin
      if (is_v2) begin
         fr_id   = {fr_shift[47:24], 8'h00};
         fr_size = {8'h00, fr_shift[23:0]};
      end else begin
         fr_id   = fr_shift[63:32];
         fr_size = is_v4 ? {4'b0, id3fw_pkg::synchsafe(fr_shift[31:0])} : fr_shift[31:0];
      end
   end

   assign fr_end = {1'b0, pos_inc} + {2'b0, fr_size};

   assign result.frame_id    = fr_id;
   assign result.id_length   = is_v2 ? id3fw_pkg::ID_LEN_3 : id3fw_pkg::ID_LEN_4;
   assign result.data_offset = pos_inc[28:0];
   assign result.data_size   = fr_size[27:0];

   always_comb begin
      phase_in   = cur_phase;
      pos_in     = pos_inc[31:0];
      tag_end_in = cur_end;
      version_in = cur_ver;
      ext_in     = cur_ext;
      shift_in   = cur_shift;
      count_in   = cur_count;
      skip_in    = cur_skip;
      push       = 1'b0;

      case (cur_phase)
         id3fw_pkg::PH_DONE: begin
            pos_in = cur_pos;
         end
         id3fw_pkg::PH_HEADER: begin
            if ((cur_pos == id3fw_pkg::POS_MAGIC0 && b != id3fw_pkg::MAGIC_I) ||
                (cur_pos == id3fw_pkg::POS_MAGIC1 && b != id3fw_pkg::MAGIC_D) ||
                (cur_pos == id3fw_pkg::POS_MAGIC2 && b != id3fw_pkg::MAGIC_3)) begin
               phase_in = id3fw_pkg::PH_DONE;
            end else begin
               if (cur_pos == id3fw_pkg::POS_VERSION) version_in = b;
               if (cur_pos == id3fw_pkg::POS_FLAGS) ext_in = b[id3fw_pkg::EXT_FLAG_BIT];
               if (cur_pos >= id3fw_pkg::POS_SIZE0) shift_in = {cur_shift[55:0], b};
               if (cur_pos == id3fw_pkg::POS_LAST) begin
                  tag_end_in = end_bf;
                  if (cur_ext) begin
                     if (id3fw_pkg::EXT_MIN_END > end_bf) begin
                        phase_in = id3fw_pkg::PH_DONE;
                     end else begin
                        phase_in = id3fw_pkg::PH_EXT;
                        shift_in = '0;
                        count_in = '0;
                     end
                  end else if (bf_ok) begin
                     phase_in = id3fw_pkg::PH_FRAME;
                     shift_in = '0;
                     count_in = '0;
                  end else begin
                     phase_in = id3fw_pkg::PH_DONE;
                  end
               end
            end
         end
         id3fw_pkg::PH_EXT: begin
            shift_in = {32'b0, ext_raw};
            count_in = ext_count;
            if (ext_count >= id3fw_pkg::EXT_SIZE_BYTES) begin
               if ({1'b0, id3fw_pkg::HDR_LEN} + {1'b0, ext_size} > {1'b0, cur_end}) begin
                  phase_in = id3fw_pkg::PH_DONE;
               end else begin
                  skip_in = ext_skip;
                  if (ext_skip != '0) begin
                     phase_in = id3fw_pkg::PH_SKIP;
                  end else if (bf_ok) begin
                     phase_in = id3fw_pkg::PH_FRAME;
                     shift_in = '0;
                     count_in = '0;
                  end else begin
                     phase_in = id3fw_pkg::PH_DONE;
                  end
               end
            end
         end
         id3fw_pkg::PH_FRAME: begin
            if (cur_count == '0 && b == '0) begin
               // padding
               phase_in = id3fw_pkg::PH_DONE;
            end else begin
               shift_in = fr_shift;
               count_in = fr_count;
               if (fr_count >= fr_hdr) begin
                  if (fr_end > {2'b0, cur_end}) begin
                     phase_in = id3fw_pkg::PH_DONE;
                  end else begin
                     push    = 1'b1;
                     skip_in = fr_size;
                     if (fr_size != '0) begin
                        phase_in = id3fw_pkg::PH_SKIP;
                     end else if (bf_ok) begin
                        phase_in = id3fw_pkg::PH_FRAME;
                        shift_in = '0;
                        count_in = '0;
                     end else begin
                        phase_in = id3fw_pkg::PH_DONE;
                     end
                  end
               end
            end
         end
         id3fw_pkg::PH_SKIP: begin
            if (cur_skip != '0) skip_in = cur_skip - 32'd1;
            if (cur_skip <= 32'd1) begin
               if (bf_ok) begin
                  phase_in = id3fw_pkg::PH_FRAME;
                  shift_in = '0;
                  count_in = '0;
               end else begin
                  phase_in = id3fw_pkg::PH_DONE;
               end
            end
         end
         default: begin
            phase_in = id3fw_pkg::PH_DONE;
         end
      endcase
   end

   // two-word output buffer; skid only fills while the output word is stalled
   assign pop = main_valid_ff && rsp_bus.ready;

   always_comb begin
      main_in       = main_ff;
      main_valid_in = main_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_in       = result;
            skid_valid_in = accept && push;
         end else begin
            main_in       = result;
            main_valid_in = accept && push;
         end
      end else if (accept && push) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= id3fw_pkg::PH_DONE;
         pos_ff        <= '0;
         tag_end_ff    <= '0;
         version_ff    <= '0;
         ext_ff        <= 1'b0;
         shift_ff      <= '0;
         count_ff      <= '0;
         skip_ff       <= '0;
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff   <= phase_in;
            pos_ff     <= pos_in;
            tag_end_ff <= tag_end_in;
            version_ff <= version_in;
            ext_ff     <= ext_in;
            shift_ff   <= shift_in;
            count_ff   <= count_in;
            skip_ff    <= skip_in;
         end
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid       = main_valid_ff;
   assign rsp_bus.frame_id    = main_ff.frame_id;
   assign rsp_bus.id_length   = main_ff.id_length;
   assign rsp_bus.data_offset = main_ff.data_offset;
   assign rsp_bus.data_size   = main_ff.data_size;

endmodule

`default_nettype wire
